// ----- rtl/core/bbvs_pkg.sv -----
package bbvs_pkg;

    // Field and datapath widths
    localparam int SAMPLE_W    = 21;
    localparam int SCALE_SHIFT = 11;
    localparam int X_W         = 32;
    localparam int COEF_W      = 16;
    localparam int Y_W         = 48;
    localparam int ACC_W       = 64;
    localparam int SPEED_W     = 32;
    localparam int CFG_IDX_W   = 3;

    // a0 = 2048: truncating divide adds this bias to negative sums
    localparam logic signed [ACC_W-1:0] A0_BIAS = 64'sd2047;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

    // Coefficient reset values
    localparam logic signed [COEF_W-1:0] B0_RST = 16'sd251;
    localparam logic signed [COEF_W-1:0] B1_RST = 16'sd0;
    localparam logic signed [COEF_W-1:0] B2_RST = -16'sd251;
    localparam logic signed [COEF_W-1:0] A1_RST = -16'sd3576;
    localparam logic signed [COEF_W-1:0] A2_RST = 16'sd1547;

    // Divide by 170 through a reciprocal: q = (mag * RECIP) >> RECIP_SHIFT.
    // Exact for mag < 2^48 with shift = 48 + ceil(log2(170)).
    localparam int          SPEED_DIV   = 170;
    localparam int          RECIP_SHIFT = 56;
    localparam logic [63:0] SPEED_RECIP =
        ((64'd1 << RECIP_SHIFT) + 64'(SPEED_DIV) - 64'd1) / 64'(SPEED_DIV);
    localparam int          RECIP_W     = 49;
    localparam int          MAG_HALF_W  = 24;
    localparam int          RECIP_LO_W  = 25;
    localparam int          SUM_W       = Y_W + RECIP_W;

    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } t_coefs;

endpackage

// ----- rtl/core/bbvs_coef_regs.sv -----
module bbvs_coef_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bbvs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bbvs_pkg::COEF_W-1:0]    i_cfg_data,
    output bbvs_pkg::t_coefs               o_coefs
);

    bbvs_pkg::t_coefs r_coefs;

    assign o_cfg_ready = 1'b1;
    assign o_coefs     = r_coefs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0 <= bbvs_pkg::B0_RST;
            r_coefs.b1 <= bbvs_pkg::B1_RST;
            r_coefs.b2 <= bbvs_pkg::B2_RST;
            r_coefs.a1 <= bbvs_pkg::A1_RST;
            r_coefs.a2 <= bbvs_pkg::A2_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                bbvs_pkg::REG_B0: r_coefs.b0 <= $signed(i_cfg_data);
                bbvs_pkg::REG_B1: r_coefs.b1 <= $signed(i_cfg_data);
                bbvs_pkg::REG_B2: r_coefs.b2 <= $signed(i_cfg_data);
                bbvs_pkg::REG_A1: r_coefs.a1 <= $signed(i_cfg_data);
                bbvs_pkg::REG_A2: r_coefs.a2 <= $signed(i_cfg_data);
                default: ;  // unmapped index: ignored
            endcase
        end
    end

endmodule

// ----- rtl/core/bbvs_biquad_core.sv -----
module bbvs_biquad_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bbvs_pkg::t_coefs                    i_coefs,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [bbvs_pkg::SAMPLE_W-1:0]       i_pressure_sample,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [bbvs_pkg::Y_W-1:0]     o_y
);

    localparam int BPROD_W = bbvs_pkg::COEF_W + bbvs_pkg::X_W + 1;

    logic                                r_x_valid;
    logic [bbvs_pkg::X_W-1:0]            r_x;
    logic                                r_y_valid;
    logic signed [bbvs_pkg::Y_W-1:0]     r_y1;
    logic signed [bbvs_pkg::Y_W-1:0]     r_y2;
    logic [bbvs_pkg::X_W-1:0]            r_x1;
    logic [bbvs_pkg::X_W-1:0]            r_x2;

    logic                                s1_ready;
    logic                                adv1;
    logic signed [BPROD_W-1:0]           p_b0;
    logic signed [BPROD_W-1:0]           p_b1;
    logic signed [BPROD_W-1:0]           p_b2;
    logic signed [bbvs_pkg::ACC_W-1:0]   p_a1;
    logic signed [bbvs_pkg::ACC_W-1:0]   p_a2;
    logic signed [bbvs_pkg::ACC_W-1:0]   n_acc;
    logic signed [bbvs_pkg::ACC_W-1:0]   n_div;
    logic signed [bbvs_pkg::Y_W-1:0]     n_y;

    assign s1_ready = !r_y_valid || i_ready;
    assign o_ready  = !r_x_valid || s1_ready;
    assign adv1     = r_x_valid && s1_ready;
    assign o_valid  = r_y_valid;
    assign o_y      = r_y1;

    // Five products, sum wraps mod 2^64
    always_comb begin
        p_b0  = i_coefs.b0 * $signed({1'b0, r_x});
        p_b1  = i_coefs.b1 * $signed({1'b0, r_x1});
        p_b2  = i_coefs.b2 * $signed({1'b0, r_x2});
        p_a1  = i_coefs.a1 * r_y1;
        p_a2  = i_coefs.a2 * r_y2;
        n_acc = bbvs_pkg::ACC_W'(p_b0) + bbvs_pkg::ACC_W'(p_b1) + bbvs_pkg::ACC_W'(p_b2)
              - p_a1 - p_a2;
        // divide by a0, truncating toward zero
        if (n_acc[bbvs_pkg::ACC_W-1]) begin
            n_div = (n_acc + bbvs_pkg::A0_BIAS) >>> bbvs_pkg::SCALE_SHIFT;
        end else begin
            n_div = n_acc >>> bbvs_pkg::SCALE_SHIFT;
        end
        n_y = $signed(n_div[bbvs_pkg::Y_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid <= 1'b0;
            r_y_valid <= 1'b0;
            r_x1      <= '0;
            r_x2      <= '0;
            r_y1      <= '0;
            r_y2      <= '0;
        end else begin
            if (o_ready) begin
                r_x_valid <= i_valid;
            end
            if (s1_ready) begin
                r_y_valid <= r_x_valid;
            end
            if (adv1) begin
                r_x2 <= r_x1;
                r_x1 <= r_x;
                r_y2 <= r_y1;
                r_y1 <= n_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_x <= {i_pressure_sample, bbvs_pkg::SCALE_SHIFT'(0)};
        end
    end

endmodule

// ----- rtl/core/bbvs_speed_div.sv -----
module bbvs_speed_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [bbvs_pkg::Y_W-1:0]     i_y,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [bbvs_pkg::SPEED_W-1:0] o_vertical_speed
);

    localparam int HW  = bbvs_pkg::MAG_HALF_W;
    localparam int RLW = bbvs_pkg::RECIP_LO_W;
    localparam int RHW = bbvs_pkg::RECIP_W - RLW;
    localparam int SW  = bbvs_pkg::SUM_W;
    localparam logic [RHW-1:0] RECIP_HI = bbvs_pkg::SPEED_RECIP[bbvs_pkg::RECIP_W-1:RLW];
    localparam logic [RLW-1:0] RECIP_LO = bbvs_pkg::SPEED_RECIP[RLW-1:0];

    logic                        r_p_valid;
    logic                        r_neg;
    logic [HW+RHW-1:0]           r_pp_hh;
    logic [HW+RLW-1:0]           r_pp_hl;
    logic [HW+RHW-1:0]           r_pp_lh;
    logic [HW+RLW-1:0]           r_pp_ll;
    logic                        r_out_valid;
    logic [bbvs_pkg::SPEED_W-1:0] r_speed;

    logic                        out_ready;
    logic [bbvs_pkg::Y_W-1:0]    mag;
    logic [SW-1:0]               sum;
    logic [bbvs_pkg::SPEED_W-1:0] quot;
    logic [bbvs_pkg::SPEED_W-1:0] n_speed;

    assign out_ready        = !r_out_valid || i_ready;
    assign o_ready          = !r_p_valid || out_ready;
    assign o_valid          = r_out_valid;
    assign o_vertical_speed = $signed(r_speed);

    assign mag = i_y[bbvs_pkg::Y_W-1] ? (bbvs_pkg::Y_W'(0) - $unsigned(i_y)) : $unsigned(i_y);

    // recombine partial products, quotient sits above the reciprocal shift
    always_comb begin
        sum = (SW'(r_pp_hh) << (HW + RLW)) + (SW'(r_pp_hl) << HW)
            + (SW'(r_pp_lh) << RLW) + SW'(r_pp_ll);
        quot = sum[bbvs_pkg::RECIP_SHIFT +: bbvs_pkg::SPEED_W];
        // speed = -(y / 170): negative y gives +q
        n_speed = r_neg ? quot : (bbvs_pkg::SPEED_W'(0) - quot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_p_valid <= i_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_p_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_neg   <= i_y[bbvs_pkg::Y_W-1];
            r_pp_hh <= mag[2*HW-1:HW] * RECIP_HI;
            r_pp_hl <= mag[2*HW-1:HW] * RECIP_LO;
            r_pp_lh <= mag[HW-1:0] * RECIP_HI;
            r_pp_ll <= mag[HW-1:0] * RECIP_LO;
        end
        if (r_p_valid && out_ready) begin
            r_speed <= n_speed;
        end
    end

endmodule

// ----- rtl/core/biquad_bandpass_vertical_speed.sv -----
// Band-pass vertical-speed filter. Each item is one unsigned 21-bit pressure
// sample; it is scaled by 2048 and run through a direct-form-I biquad with
// programmable signed 16-bit coefficients b0, b1, b2, a1, a2 (a0 fixed at
// 2048). The new output state is the sum divided by 2048, truncating toward
// zero and kept to 48 bits; the result item is -(state / 170), truncated
// toward zero and wrapped to 32 bits, in cm/s. Exactly one result per item.
// Rate: one item per cycle while i_ready stays high. An accepted item passes
// the input, feedback, partial-product and output registers. The rate is set
// by the feedback stage, where the five coefficient products, the sum and the
// divide by 2048 close the state recurrence combinationally. The divide by
// 170 runs behind it as a reciprocal multiply split into four partial
// products, then a recombine stage. Coefficients are written through the cfg
// channel (index 0..4 = b0, b1, b2, a1, a2; other indexes are ignored) and
// must only be changed while the block is idle. Filter state clears on reset.
module biquad_bandpass_vertical_speed (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [bbvs_pkg::SAMPLE_W-1:0]       i_pressure_sample,
    // result channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [bbvs_pkg::SPEED_W-1:0] o_vertical_speed,
    // coefficient write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bbvs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bbvs_pkg::COEF_W-1:0]         i_cfg_data
);

    bbvs_pkg::t_coefs                coefs;
    logic                            y_valid;
    logic                            y_ready;
    logic signed [bbvs_pkg::Y_W-1:0] y_state;

    // coefficient bank
    bbvs_coef_regs u_coef_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coefs     (coefs)
    );

    // input register + feedback stage, holds x1/x2/y1/y2
    bbvs_biquad_core u_biquad_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_coefs           (coefs),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_pressure_sample (i_pressure_sample),
        .o_valid           (y_valid),
        .i_ready           (y_ready),
        .o_y               (y_state)
    );

    // y / 170, negate, output register
    bbvs_speed_div u_speed_div (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (y_valid),
        .o_ready          (y_ready),
        .i_y              (y_state),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_vertical_speed (o_vertical_speed)
    );

endmodule

// ----- tb/bbvs_checker.sv -----
`timescale 1ns / 100ps

module bbvs_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_smp_valid,
    input  logic                                i_smp_ready,
    input  logic [bbvs_pkg::SAMPLE_W-1:0]       i_smp_pressure,
    input  logic                                i_res_valid,
    input  logic                                i_res_ready,
    input  logic signed [bbvs_pkg::SPEED_W-1:0] i_res_speed,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [bbvs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bbvs_pkg::COEF_W-1:0]         i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_speeds_checked
);
    import bbvs_pkg::*;

    localparam longint A0_GAIN    = longint'(1) << SCALE_SHIFT;
    localparam int     MAX_REPORT = 10;

    // filter model state
    t_coefs                    coefs;
    logic [X_W-1:0]            x_d1, x_d2;
    logic signed [Y_W-1:0]     y_d1, y_d2;
    logic signed [SPEED_W-1:0] speed_q [$];
    int                        reported = 0;

    initial begin
        o_fail_count     = 0;
        o_pending        = 0;
        o_speeds_checked = 0;
    end

    // one biquad step: updates the state, returns the expected speed
    function automatic logic signed [SPEED_W-1:0] advance_filter(
        input logic [SAMPLE_W-1:0] pressure
    );
        logic [X_W-1:0]        x;
        longint                acc;
        logic signed [Y_W-1:0] y;
        x   = X_W'(pressure) << SCALE_SHIFT;
        acc = longint'(coefs.b0) * longint'(x)
            + longint'(coefs.b1) * longint'(x_d1)
            + longint'(coefs.b2) * longint'(x_d2)
            - longint'(coefs.a1) * longint'(y_d1)
            - longint'(coefs.a2) * longint'(y_d2);
        y    = Y_W'(acc / A0_GAIN);
        x_d2 = x_d1;
        x_d1 = x;
        y_d2 = y_d1;
        y_d1 = y;
        return SPEED_W'(-(longint'(y) / longint'(SPEED_DIV)));
    endfunction

    always @(posedge i_clk) begin
        logic signed [SPEED_W-1:0] want;
        if (!i_rst_n) begin
            coefs = '{B0_RST, B1_RST, B2_RST, A1_RST, A2_RST};
            x_d1  = '0;
            x_d2  = '0;
            y_d1  = '0;
            y_d2  = '0;
            speed_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_B0:  coefs.b0 = i_cfg_data;
                    REG_B1:  coefs.b1 = i_cfg_data;
                    REG_B2:  coefs.b2 = i_cfg_data;
                    REG_A1:  coefs.a1 = i_cfg_data;
                    REG_A2:  coefs.a2 = i_cfg_data;
                    default: ;
                endcase
            end
            // results leave before this edge's sample is queued
            if (i_res_valid && i_res_ready) begin
                if (speed_q.size() == 0) begin
                    o_fail_count++;
                    if (reported < MAX_REPORT) begin
                        reported++;
                        $display("checker: unexpected speed item %0d, nothing queued",
                                 i_res_speed);
                    end
                end else begin
                    want = speed_q.pop_front();
                    if (i_res_speed !== want) begin
                        o_fail_count++;
                        if (reported < MAX_REPORT) begin
                            reported++;
                            $display("checker: speed item %0d: expected %0d, got %0d",
                                     o_speeds_checked, want, i_res_speed);
                        end
                    end
                    o_speeds_checked++;
                end
            end
            if (i_smp_valid && i_smp_ready)
                speed_q.push_back(advance_filter(i_smp_pressure));
        end
        o_pending = speed_q.size();
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

// Top of the vertical-speed filter bench. Only stimulus and the verdict live
// here; bbvs_checker watches all three channels, models the biquad and
// compares every speed item.
module testbench;
    import bbvs_pkg::*;

    localparam int SAMPLE_MAX      = (1 << SAMPLE_W) - 1;
    localparam int ITEMS_PER_PHASE = 216;
    localparam int MAX_GAP         = 6;
    localparam int LONG_HOLD       = 200;   // sink stall that backs up the pipe
    localparam int DRAIN_CYCLES    = 16;    // leave slack after the drain
    localparam int CYCLE_LIMIT     = 300000;

    localparam logic signed [COEF_W-1:0] COEF_MAX = 16'sh7FFF;
    localparam logic signed [COEF_W-1:0] COEF_MIN = 16'sh8000;

    localparam logic [CFG_IDX_W-1:0] COEF_REGS [5] =
        '{REG_B0, REG_B1, REG_B2, REG_A1, REG_A2};
    localparam logic signed [COEF_W-1:0] NOMINAL_COEFS [5] =
        '{B0_RST, B1_RST, B2_RST, A1_RST, A2_RST};

    // coefficient sets, one per phase; the first runs on reset values
    typedef enum int {
        PH_DEFAULT,
        PH_ALL_MIN,
        PH_ALL_MAX,
        PH_ALTERNATE,
        PH_ZERO,
        PH_NOMINAL,
        PH_RANDOM_A,
        PH_RANDOM_B,
        PH_COUNT
    } t_phase;

    // corner samples, run first on the reset coefficients
    localparam logic [SAMPLE_W-1:0] CORNER_SAMPLES [20] = '{
        21'd0, 21'd0, 21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 21'd0, 21'd0, 21'd0,
        21'h155555, 21'h0AAAAA, 21'h155555, 21'h0AAAAA, 21'd1, 21'h100000,
        21'd101325, 21'd101325, 21'd101330, 21'd101320, 21'h1FFFFF, 21'd0
    };

    logic                        i_clk             = 1'b0;
    logic                        i_rst_n           = 1'b0;
    logic                        i_valid           = 1'b0;
    logic                        o_ready;
    logic [SAMPLE_W-1:0]         i_pressure_sample = '0;
    logic                        o_valid;
    logic                        i_ready           = 1'b0;
    logic signed [SPEED_W-1:0]   o_vertical_speed;
    logic                        i_cfg_valid       = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index       = '0;
    logic [COEF_W-1:0]           i_cfg_data        = '0;

    int fail_count;
    int pending;
    int speeds_checked;
    int samples_sent = 0;
    int coef_writes  = 0;
    int long_holds   = 0;
    bit src_burst    = 1'b0;

    always #2 i_clk = ~i_clk;

    biquad_bandpass_vertical_speed uut (.*);

    bbvs_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_smp_valid      (i_valid),
        .i_smp_ready      (o_ready),
        .i_smp_pressure   (i_pressure_sample),
        .i_res_valid      (o_valid),
        .i_res_ready      (i_ready),
        .i_res_speed      (o_vertical_speed),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_speeds_checked (speeds_checked)
    );

    // Handshakes are judged at the falling edge: inputs only move at the
    // rising edge, so what is seen there is what the next rising edge takes.
    // Every task starts and ends on a rising edge.

    // Offer one sample after a random gap; valid stays up until taken.
    task automatic send_sample(input logic [SAMPLE_W-1:0] pressure);
        int gap;
        if ($urandom_range(0, 31) == 0)
            src_burst = !src_burst;
        gap = src_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_pressure_sample <= pressure;
        do @(negedge i_clk); while (!o_ready);
        @(posedge i_clk);
        samples_sent++;
    endtask

    // Caller drops i_cfg_valid after its last write, so back-to-back writes
    // never lower and raise it in one step.
    task automatic write_coef(input logic [CFG_IDX_W-1:0] index,
                              input logic [COEF_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        coef_writes++;
    endtask

    // Block is idle once every queued speed item has come out.
    task automatic wait_idle();
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    // Result sink: random stalls per item, bursts with none, and two long
    // holds that fill the pipe and push back on the sample channel.
    initial begin : speed_sink
        int hold;
        int taken;
        bit burst;
        taken = 0;
        burst = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 63) == 0)
                burst = !burst;
            hold = burst ? 0 : $urandom_range(0, MAX_GAP);
            if (taken == 300 || taken == 1100) begin
                hold = LONG_HOLD;
                long_holds++;
            end
            if (hold > 0) begin
                i_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(negedge i_clk); while (!(o_valid && i_ready));
            @(posedge i_clk);
            taken++;
        end
    end

    // Watchdog on a cycle count.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb: timeout after %0d cycles", cycles);
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        int                        walk;
        int                        pick;
        logic [SAMPLE_W-1:0]       pressure;
        logic signed [COEF_W-1:0]  value;
        t_phase                    phase;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners: zero, full scale, steps between them, alternating bits
        foreach (CORNER_SAMPLES[k])
            send_sample(CORNER_SAMPLES[k]);

        for (int p = 0; p < PH_COUNT; p++) begin
            phase = t_phase'(p);
            if (phase != PH_DEFAULT) begin
                // new coefficients only with the filter drained
                wait_idle();
                for (int r = 0; r < 5; r++) begin
                    case (phase)
                        PH_ALL_MIN:   value = COEF_MIN;
                        PH_ALL_MAX:   value = COEF_MAX;
                        PH_ALTERNATE: value = (r % 2 == 0) ? COEF_MAX : COEF_MIN;
                        PH_ZERO:      value = '0;
                        PH_NOMINAL:   value = NOMINAL_COEFS[r];
                        default:      value = COEF_W'($urandom);
                    endcase
                    write_coef(COEF_REGS[r], value);
                end
                // index past the last register must be dropped
                write_coef(CFG_IDX_W'($urandom_range(int'(REG_A2) + 1,
                                                     (1 << CFG_IDX_W) - 1)),
                           COEF_W'($urandom));
                i_cfg_valid <= 1'b0;
            end

            // Mostly a slow pressure walk around ground level, with some
            // full-range noise and full-scale jumps. The min/max sets blow
            // the feedback up, which wraps the sum, the state and the speed.
            walk = $urandom_range(30000, 110000);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 15);
                if (pick == 0) begin
                    pressure = $urandom_range(0, 1) ? SAMPLE_W'(SAMPLE_MAX) : '0;
                end else if (pick < 3) begin
                    pressure = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
                end else begin
                    walk = walk + int'($urandom_range(0, 40)) - 20;
                    if (walk < 0)
                        walk = 0;
                    if (walk > SAMPLE_MAX)
                        walk = SAMPLE_MAX;
                    pressure = SAMPLE_W'(walk);
                end
                send_sample(pressure);
            end
            i_valid <= 1'b0;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d samples in %0d coefficient sets, %0d speed items checked",
                 samples_sent, int'(PH_COUNT), speeds_checked);
        $display("tb: %0d coefficient writes, %0d long sink stalls",
                 coef_writes, long_holds);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: %0d failures, %0d speed items missing", fail_count, pending);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
